// ===== src/nearest_template_minmax_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// nearest_template_minmax_classifier_defines
// assertion macros shared by the classifier sources
// ----------------------------------------------------------------------------
`ifndef NEAREST_TEMPLATE_MINMAX_CLASSIFIER_DEFINES_SVH
`define NEAREST_TEMPLATE_MINMAX_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define NTMC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NTMC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ntmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntmc_pkg
// shared constants and types of the nearest template classifier
// ----------------------------------------------------------------------------
package ntmc_pkg;

	localparam int NUM_LABELS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int LABEL_W = 4;
	localparam int ROW_W   = 16;
	localparam int DIST_W  = 18;

	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	// operations of the shared arithmetic unit
	typedef enum logic [0:0] {
		ALU_MID = 1'b0,
		ALU_ABS = 1'b1
	} alu_op_t;

endpackage

// ===== src/ntmc_ram.sv =====
// ----------------------------------------------------------------------------
// ntmc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ntmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ntmc_alu.sv =====
// ----------------------------------------------------------------------------
// ntmc_alu
// shared adder: floored midpoint, or absolute difference added to a sum
// ----------------------------------------------------------------------------
module ntmc_alu #(
	parameter int SAMPLE_BITS = ntmc_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_W       = ntmc_pkg::DIST_W
) (
	input  ntmc_pkg::alu_op_t        op,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic signed [SAMPLE_BITS-1:0] b,
	input  logic [ACC_W-1:0]         acc_in,
	output logic signed [SAMPLE_BITS-1:0] mid,
	output logic [ACC_W-1:0]         acc_out
);

	logic signed [SAMPLE_BITS:0] a_x;
	logic signed [SAMPLE_BITS:0] b_x;
	logic signed [SAMPLE_BITS:0] sum;
	logic [SAMPLE_BITS:0]        mag;
	logic                        sub;

	always_comb begin
		sub = (op == ntmc_pkg::ALU_ABS);
		a_x = (SAMPLE_BITS+1)'(a);
		b_x = (SAMPLE_BITS+1)'(b);
		// one adder serves both: b is inverted for the difference
		sum = a_x + (sub ? ~b_x : b_x) + (SAMPLE_BITS+1)'(sub);
		mid = sum[SAMPLE_BITS:1];
		mag = sum[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-sum) : sum;
		acc_out = acc_in + ACC_W'(mag);
	end

endmodule

// ===== src/nearest_template_minmax_classifier.sv =====
// ----------------------------------------------------------------------------
// nearest_template_minmax_classifier: min/max/mid nearest template match
// samples and pattern row ends: one word per cycle, stalled only during a test walk
// test row end: walk of mid, then per slot fetch and, for a valid slot, dmin,
// dmax, tmid, dmid, cmp; input stalled until done; one shared adder, one ram port
// reset (async, active low) clears running min/max and all slot valid bits
// ----------------------------------------------------------------------------
`include "nearest_template_minmax_classifier_defines.svh"

module nearest_template_minmax_classifier #(
	parameter int NUM_LABELS  = ntmc_pkg::NUM_LABELS_DEF,
	parameter int SAMPLE_BITS = ntmc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             action,
	input  logic [ntmc_pkg::LABEL_W-1:0]     label,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	input  logic                             last,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [ntmc_pkg::LABEL_W-1:0]     true_label,
	output logic [ntmc_pkg::LABEL_W-1:0]     best_label,
	output logic                             matched,
	output logic signed [ntmc_pkg::ROW_W-1:0] row_min,
	output logic signed [ntmc_pkg::ROW_W-1:0] row_max,
	output logic signed [ntmc_pkg::ROW_W-1:0] row_mid,
	output logic [ntmc_pkg::DIST_W-1:0]      best_distance
);

	localparam int IDX_W  = $clog2(NUM_LABELS);
	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int ACC_W  = (SUM_W > ntmc_pkg::DIST_W) ? SUM_W : ntmc_pkg::DIST_W;
	localparam int WIDE_W = (SAMPLE_BITS > ntmc_pkg::ROW_W) ? SAMPLE_BITS : ntmc_pkg::ROW_W;

	localparam logic signed [SAMPLE_BITS-1:0] S_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LABELS - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MID   = 9'b000000010,
		S_FETCH = 9'b000000100,
		S_DMIN  = 9'b000001000,
		S_DMAX  = 9'b000010000,
		S_TMID  = 9'b000100000,
		S_DMID  = 9'b001000000,
		S_CMP   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [SAMPLE_BITS-1:0] run_min_q, run_max_q;
	logic signed [SAMPLE_BITS-1:0] mn_q, mx_q, mid_q, tmid_q;
	logic signed [SAMPLE_BITS-1:0] new_min, new_max;
	logic [ntmc_pkg::LABEL_W-1:0]  label_q;
	logic [NUM_LABELS-1:0]         valid_q;
	logic [IDX_W-1:0]              idx_q, best_idx_q;
	logic [ACC_W-1:0]              acc_q, best_q;
	logic                          matched_q;
	logic                          result_valid_q;

	logic                          item_fire, label_ok, tbl_we;
	logic [2*SAMPLE_BITS-1:0]      rd_data;
	logic signed [SAMPLE_BITS-1:0] t_min, t_max;

	ntmc_pkg::alu_op_t             alu_op;
	logic signed [SAMPLE_BITS-1:0] alu_a, alu_b, alu_mid;
	logic [ACC_W-1:0]              alu_acc_in, alu_acc_out;

	logic signed [WIDE_W-1:0]      mn_w, mx_w, mid_w;

	assign item_ready   = (state_q == S_IDLE);
	assign item_fire    = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign label_ok     = (int'(label) < NUM_LABELS);
	assign tbl_we       = item_fire && last && !action && label_ok;

	assign new_min = (sample < run_min_q) ? sample : run_min_q;
	assign new_max = (sample > run_max_q) ? sample : run_max_q;

	// slot word: max in the upper half, min in the lower half
	ntmc_ram #(
		.WIDTH(2 * SAMPLE_BITS),
		.DEPTH(NUM_LABELS)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(IDX_W'(label)),
		.wdata({new_max, new_min}),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign t_min = rd_data[SAMPLE_BITS-1:0];
	assign t_max = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

	always_comb begin
		alu_op     = ntmc_pkg::ALU_ABS;
		alu_a      = t_min;
		alu_b      = mn_q;
		alu_acc_in = acc_q;
		unique case (state_q)
			S_MID: begin
				alu_op = ntmc_pkg::ALU_MID;
				alu_a  = mn_q;
				alu_b  = mx_q;
			end
			S_DMIN: begin
				alu_acc_in = '0;
			end
			S_DMAX: begin
				alu_a = t_max;
				alu_b = mx_q;
			end
			S_TMID: begin
				alu_op = ntmc_pkg::ALU_MID;
				alu_a  = t_min;
				alu_b  = t_max;
			end
			S_DMID: begin
				alu_a = tmid_q;
				alu_b = mid_q;
			end
			default: begin
			end
		endcase
	end

	ntmc_alu #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.ACC_W      (ACC_W)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.acc_in (alu_acc_in),
		.mid    (alu_mid),
		.acc_out(alu_acc_out)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			run_min_q      <= S_HI;
			run_max_q      <= S_LO;
			valid_q        <= '0;
			idx_q          <= '0;
			matched_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// a finished walk always loads the output word, an unread one is kept
			result_valid_q <= (state_q == S_DONE) || (result_valid_q && !result_ready);
			unique case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						if (last) begin
							run_min_q <= S_HI;
							run_max_q <= S_LO;
							if (!action) begin
								if (label_ok) begin
									valid_q[IDX_W'(label)] <= 1'b1;
								end
							end else begin
								idx_q     <= '0;
								matched_q <= 1'b0;
								state_q   <= S_MID;
							end
						end else begin
							run_min_q <= new_min;
							run_max_q <= new_max;
						end
					end
				end
				S_MID: state_q <= S_FETCH;
				S_FETCH: begin
					// an empty slot is skipped in S_FETCH without using the adder
					if (valid_q[idx_q]) begin
						state_q <= S_DMIN;
					end else if (idx_q == IDX_LAST) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DMIN: state_q <= S_DMAX;
				S_DMAX: state_q <= S_TMID;
				S_TMID: state_q <= S_DMID;
				S_DMID: state_q <= S_CMP;
				S_CMP: begin
					if (!matched_q || (acc_q < best_q)) begin
						matched_q <= 1'b1;
					end
					if (idx_q == IDX_LAST) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					if (!result_valid_q || result_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (item_fire && last && action) begin
			mn_q    <= new_min;
			mx_q    <= new_max;
			label_q <= label;
			best_q  <= '0;
		end
		if (state_q == S_MID) begin
			mid_q <= alu_mid;
		end
		if (state_q == S_TMID) begin
			tmid_q <= alu_mid;
		end
		if (state_q == S_DMIN || state_q == S_DMAX || state_q == S_DMID) begin
			acc_q <= alu_acc_out;
		end
		if (state_q == S_CMP && (!matched_q || (acc_q < best_q))) begin
			best_q     <= acc_q;
			best_idx_q <= idx_q;
		end
	end

	assign mn_w  = WIDE_W'(mn_q);
	assign mx_w  = WIDE_W'(mx_q);
	assign mid_w = WIDE_W'(mid_q);

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!result_valid_q || result_ready)) begin
			true_label    <= label_q;
			best_label    <= matched_q ? ntmc_pkg::LABEL_W'(best_idx_q) : '0;
			matched       <= matched_q;
			row_min       <= mn_w[ntmc_pkg::ROW_W-1:0];
			row_max       <= mx_w[ntmc_pkg::ROW_W-1:0];
			row_mid       <= mid_w[ntmc_pkg::ROW_W-1:0];
			best_distance <= (best_q > ACC_W'(ntmc_pkg::DIST_SAT)) ? ntmc_pkg::DIST_SAT
				: best_q[ntmc_pkg::DIST_W-1:0];
		end
	end

	`NTMC_ASSERT_NOW(a_empty_result, result_valid && !matched,
		best_label == '0 && best_distance == '0, "empty table word not zeroed")
	`NTMC_ASSERT_NEXT(a_pattern_no_stall, item_valid && item_ready && last && !action,
		item_ready, "pattern row end stalled the input")
	`NTMC_ASSERT_NEXT(a_test_walk_starts, item_valid && item_ready && last && action,
		!item_ready && state_q == S_MID, "test row end did not start the table walk")

endmodule
